FILE: rtl/quaternion_to_euler_angles_top_macros.svh
// Assertion macros shared by the quaternion to Euler angle converter modules.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/qte_pkg.sv
// Types and constants shared by the quaternion to Euler angle converter.
package qte_pkg;

    localparam int OPND_W      = 64;
    localparam int PROD_W      = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 33;
    localparam int NORM_STEPS   = 6;
    localparam int NORM_DROP    = 35;
    localparam int CORDIC_LAT   = NORM_STEPS + CORDIC_STEPS + 3;

    localparam int SQRT_STEPS = 31;
    localparam int ROOT_LAT   = SQRT_STEPS + 3;
    localparam int BACK_LAT   = ROOT_LAT + CORDIC_LAT;

    localparam logic signed [CW-1:0] Z_HALF    = 33'sd589824000;
    localparam logic signed [CW-1:0] ROUND_OFS = 33'sd32768;
    localparam logic signed [15:0]   ANG_LIM   = 16'sd18000;
    localparam logic signed [15:0]   PITCH_LIM = 16'sd9000;

    localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
        33'sd23437865, 33'sd11730358, 33'sd5866610, 33'sd2933484,
        33'sd1466765, 33'sd733385, 33'sd366693, 33'sd183347,
        33'sd91673, 33'sd45837, 33'sd22918, 33'sd11459,
        33'sd5730, 33'sd2865, 33'sd1432, 33'sd716,
        33'sd358, 33'sd179, 33'sd90, 33'sd45
    };

    typedef logic signed [OPND_W-1:0] opnd_t;

    typedef struct packed {
        opnd_t roll_y;
        opnd_t roll_x;
        opnd_t yaw_y;
        opnd_t yaw_x;
        opnd_t pitch_s;
    } opnd_set_t;

    typedef struct packed {
        logic f1_vld;
        logic f2_vld;
    } front_stat_t;

    typedef struct packed {
        logic yneg;
        logic xneg;
        logic zero;
    } vec_flags_t;

    typedef struct packed {
        logic clamp;
        logic neg;
    } pitch_flags_t;

    typedef struct packed {
        pitch_flags_t        pf;
        logic signed [30:0] s30;
    } root_side_t;

endpackage

FILE: rtl/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to Z-Y-X Euler angle converter.
// Takes one quaternion per cycle while s_tready is high and returns roll, pitch and yaw
// in centidegrees, one result per transfer, at a sustained rate of one item per clock
// while m_tready is high. An input transfer reaches its result through two front-end
// stages, one queue slot, the 34-stage pitch square root and the 33-stage CORDIC in
// series. A stall on the output freezes the angle pipelines, and the four-entry queue
// then absorbs the items already inside the front end.
`include "quaternion_to_euler_angles_top_macros.svh"
module quaternion_to_euler_angles_top import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_centideg, pitch_centideg, yaw_centideg, zero pad
    output logic [0:0]  m_tuser    // pitch_clamped
);

    logic                  in_xfer;
    opnd_set_t             front_opnd, head;
    logic                  front_vld, fifo_ne, pop, back_en;
    front_stat_t           fstat;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic                  bvld_reg [BACK_LAT];
    logic signed [15:0]    roll_cd, yaw_cd, pitch_cd;
    logic signed [15:0]    roll_dly_reg [ROOT_LAT];
    logic signed [15:0]    yaw_dly_reg  [ROOT_LAT];
    pitch_flags_t          pf_dly_reg   [CORDIC_LAT];
    logic [30:0]           root_c;
    root_side_t            root_side;
    logic signed [15:0]    pitch_sel;
    logic signed [14:0]    pitch_out;
    pitch_flags_t          pf_out;

    assign s_tready = (4'(fifo_cnt) + 4'(fstat.f1_vld) + 4'(fstat.f2_vld)) < 4'(FIFO_DEPTH);
    assign in_xfer  = s_tvalid && s_tready;

    qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .quat_w   (signed'(s_tdata[15:0])),
        .quat_x   (signed'(s_tdata[31:16])),
        .quat_y   (signed'(s_tdata[47:32])),
        .quat_z   (signed'(s_tdata[63:48])),
        .opnd     (front_opnd),
        .opnd_vld (front_vld),
        .stat     (fstat)
    );

    qte_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_vld),
        .push_data (front_opnd),
        .pop       (pop),
        .head      (head),
        .not_empty (fifo_ne),
        .count     (fifo_cnt)
    );

    assign m_tvalid = bvld_reg[BACK_LAT-1];
    assign back_en  = !m_tvalid || m_tready;
    assign pop      = fifo_ne && back_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BACK_LAT; i++) begin
                bvld_reg[i] <= 1'b0;
            end
        end else if (back_en) begin
            bvld_reg[0] <= pop;
            for (int i = 1; i < BACK_LAT; i++) begin
                bvld_reg[i] <= bvld_reg[i-1];
            end
        end
    end

    qte_cordic u_roll (
        .aclk  (aclk),
        .en    (back_en),
        .y_in  (head.roll_y),
        .x_in  (head.roll_x),
        .angle (roll_cd)
    );

    qte_cordic u_yaw (
        .aclk  (aclk),
        .en    (back_en),
        .y_in  (head.yaw_y),
        .x_in  (head.yaw_x),
        .angle (yaw_cd)
    );

    qte_root #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_root (
        .aclk    (aclk),
        .en      (back_en),
        .pitch_s (head.pitch_s),
        .root_c  (root_c),
        .side    (root_side)
    );

    qte_cordic u_pitch (
        .aclk  (aclk),
        .en    (back_en),
        .y_in  (opnd_t'(root_side.s30)),
        .x_in  (signed'(OPND_W'(root_c))),
        .angle (pitch_cd)
    );

    always_ff @(posedge aclk) begin
        if (back_en) begin
            roll_dly_reg[0] <= roll_cd;
            yaw_dly_reg[0]  <= yaw_cd;
            for (int i = 1; i < ROOT_LAT; i++) begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
            pf_dly_reg[0] <= root_side.pf;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                pf_dly_reg[i] <= pf_dly_reg[i-1];
            end
        end
    end

    assign pf_out = pf_dly_reg[CORDIC_LAT-1];

    always_comb begin
        if (pf_out.clamp) begin
            pitch_sel = pf_out.neg ? -PITCH_LIM : PITCH_LIM;
        end else if (pitch_cd > PITCH_LIM) begin
            pitch_sel = PITCH_LIM;
        end else if (pitch_cd < -PITCH_LIM) begin
            pitch_sel = -PITCH_LIM;
        end else begin
            pitch_sel = pitch_cd;
        end
        pitch_out = 15'(pitch_sel);
    end

    assign m_tdata = {1'b0, yaw_dly_reg[ROOT_LAT-1], pitch_out, roll_dly_reg[ROOT_LAT-1]};
    assign m_tuser = pf_out.clamp;

    `QTE_ASSERT(a_credit, (4'(fifo_cnt) + 4'(fstat.f1_vld) + 4'(fstat.f2_vld)) <= 4'(FIFO_DEPTH), "credit exceeded")
    `QTE_ASSERT(a_clamp_value, !(m_tvalid && pf_out.clamp) || pitch_sel == PITCH_LIM || pitch_sel == -PITCH_LIM, "clamped pitch not at limit")
    `QTE_ASSERT(a_roll_range, !m_tvalid || (roll_dly_reg[ROOT_LAT-1] <= ANG_LIM && roll_dly_reg[ROOT_LAT-1] >= -ANG_LIM), "roll out of range")

endmodule

FILE: rtl/qte_front.sv
// Front end: forms the quaternion products, the roll and yaw operand pairs and the pitch operand.
module qte_front import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_xfer,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output opnd_set_t          opnd,
    output logic               opnd_vld,
    output front_stat_t        stat
);

    localparam opnd_t ONE = opnd_t'(64'sd1 <<< (2 * QUAT_FRAC_BITS));

    logic signed [PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PROD_W-1:0] p_wz_reg, p_xy_reg, p_wy_reg, p_zx_reg;
    logic                     f1_vld_reg, f2_vld_reg;
    opnd_set_t                opnd_reg, opnd_next;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            p_wx_reg <= 32'(quat_w) * 32'(quat_x);
            p_yz_reg <= 32'(quat_y) * 32'(quat_z);
            p_xx_reg <= 32'(quat_x) * 32'(quat_x);
            p_yy_reg <= 32'(quat_y) * 32'(quat_y);
            p_zz_reg <= 32'(quat_z) * 32'(quat_z);
            p_wz_reg <= 32'(quat_w) * 32'(quat_z);
            p_xy_reg <= 32'(quat_x) * 32'(quat_y);
            p_wy_reg <= 32'(quat_w) * 32'(quat_y);
            p_zx_reg <= 32'(quat_z) * 32'(quat_x);
        end
    end

    always_comb begin
        opnd_next.roll_y  = (opnd_t'(p_wx_reg) + opnd_t'(p_yz_reg)) <<< 1;
        opnd_next.roll_x  = ONE - ((opnd_t'(p_xx_reg) + opnd_t'(p_yy_reg)) <<< 1);
        opnd_next.yaw_y   = (opnd_t'(p_wz_reg) + opnd_t'(p_xy_reg)) <<< 1;
        opnd_next.yaw_x   = ONE - ((opnd_t'(p_yy_reg) + opnd_t'(p_zz_reg)) <<< 1);
        opnd_next.pitch_s = (opnd_t'(p_wy_reg) - opnd_t'(p_zx_reg)) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (f1_vld_reg) begin
            opnd_reg <= opnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else begin
            f1_vld_reg <= in_xfer;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    assign opnd        = opnd_reg;
    assign opnd_vld    = f2_vld_reg;
    assign stat.f1_vld = f1_vld_reg;
    assign stat.f2_vld = f2_vld_reg;

endmodule

FILE: rtl/qte_fifo.sv
// Short queue that decouples the front end from the angle pipelines.
`include "quaternion_to_euler_angles_top_macros.svh"
module qte_fifo import qte_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  opnd_set_t             push_data,
    input  logic                  pop,
    output opnd_set_t             head,
    output logic                  not_empty,
    output logic [FIFO_CNT_W-1:0] count
);

    opnd_set_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

    `QTE_ASSERT(a_no_overflow, !(push && cnt_reg == FIFO_CNT_W'(FIFO_DEPTH)), "queue overflow")
    `QTE_ASSERT(a_no_underflow, !(pop && cnt_reg == '0), "queue underflow")
    `QTE_ASSERT_NEXT(a_count_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "bad count")

endmodule

FILE: rtl/qte_root.sv
// Pitch preparation: clamp test, scaling to Q30 and a pipelined integer square root.
module qte_root import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        en,
    input  opnd_t       pitch_s,
    output logic [30:0] root_c,
    output root_side_t  side
);

    localparam logic [OPND_W-1:0] ONE = 64'd1 << (2 * QUAT_FRAC_BITS);
    localparam int D   = 30 - 2 * QUAT_FRAC_BITS;
    localparam int SHL = (D >= 0) ? D : 0;
    localparam int SHR = (D < 0) ? -D : 0;

    logic [OPND_W-1:0] sm;
    logic [29:0]       sm30, sm30_reg;
    logic [59:0]       sq_reg;
    root_side_t        side_in;
    root_side_t        side_reg [ROOT_LAT];
    logic [60:0]       rv_reg [SQRT_STEPS+1];
    logic [60:0]       rr_reg [SQRT_STEPS+1];

    always_comb begin
        sm               = pitch_s[OPND_W-1] ? -pitch_s : pitch_s;
        sm30             = 30'((sm << SHL) >> SHR);
        side_in.pf.neg   = pitch_s[OPND_W-1];
        side_in.pf.clamp = (sm >= ONE);
        side_in.s30      = pitch_s[OPND_W-1] ? -signed'({1'b0, sm30}) : signed'({1'b0, sm30});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sm30_reg    <= sm30;
            side_reg[0] <= side_in;
            sq_reg      <= sm30_reg * sm30_reg;
            rv_reg[0]   <= (61'd1 << 60) - {1'b0, sq_reg};
            rr_reg[0]   <= '0;
            for (int i = 1; i < ROOT_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [60:0] BITK = 61'd1 << (60 - 2 * k);
        logic [60:0] trial;
        assign trial = rr_reg[k] + BITK;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rv_reg[k] >= trial) begin
                    rv_reg[k+1] <= rv_reg[k] - trial;
                    rr_reg[k+1] <= (rr_reg[k] >> 1) + BITK;
                end else begin
                    rv_reg[k+1] <= rv_reg[k];
                    rr_reg[k+1] <= rr_reg[k] >> 1;
                end
            end
        end
    end

    assign root_c = 31'(rr_reg[SQRT_STEPS]);
    assign side   = side_reg[ROOT_LAT-1];

endmodule

FILE: rtl/qte_cordic.sv
// Pipelined vectoring CORDIC that returns atan2 in centidegrees.
module qte_cordic import qte_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  opnd_t              y_in,
    input  opnd_t              x_in,
    output logic signed [15:0] angle
);

    logic [OPND_W-1:0]     ym_in, xm_in;
    logic [OPND_W-1:0]     m_reg  [NORM_STEPS+1];
    logic [OPND_W-1:0]     ym_reg [NORM_STEPS+1];
    logic [OPND_W-1:0]     xm_reg [NORM_STEPS+1];
    vec_flags_t            fl_reg [NORM_STEPS+1];
    logic signed [CW-1:0]  cx_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]  cy_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]  cz_reg [CORDIC_STEPS+1];
    logic                  zr_reg [CORDIC_STEPS+1];
    logic [28:0]           xr, yr;
    logic signed [CW-1:0]  xa, ya, xs, ys, x0, y0, z0;
    logic signed [CW-1:0]  zsum, zq;
    logic signed [15:0]    angle_reg, angle_next;

    assign ym_in = y_in[OPND_W-1] ? -y_in : y_in;
    assign xm_in = x_in[OPND_W-1] ? -x_in : x_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            ym_reg[0]      <= ym_in;
            xm_reg[0]      <= xm_in;
            m_reg[0]       <= (ym_in > xm_in) ? ym_in : xm_in;
            fl_reg[0].yneg <= y_in[OPND_W-1];
            fl_reg[0].xneg <= x_in[OPND_W-1];
            fl_reg[0].zero <= (ym_in == '0) && (xm_in == '0);
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic do_shift;
        assign do_shift = (m_reg[j][OPND_W-1 -: SH] == '0);
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[j+1]  <= do_shift ? (m_reg[j] << SH) : m_reg[j];
                ym_reg[j+1] <= do_shift ? (ym_reg[j] << SH) : ym_reg[j];
                xm_reg[j+1] <= do_shift ? (xm_reg[j] << SH) : xm_reg[j];
                fl_reg[j+1] <= fl_reg[j];
            end
        end
    end

    always_comb begin
        xr = 29'(xm_reg[NORM_STEPS] >> NORM_DROP);
        yr = 29'(ym_reg[NORM_STEPS] >> NORM_DROP);
        xa = signed'(CW'(xr));
        ya = signed'(CW'(yr));
        xs = fl_reg[NORM_STEPS].xneg ? -xa : xa;
        ys = fl_reg[NORM_STEPS].yneg ? -ya : ya;
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x0 = ys;
                y0 = -xs;
                z0 = Z_HALF;
            end else begin
                x0 = -ys;
                y0 = xs;
                z0 = -Z_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= x0;
            cy_reg[0] <= y0;
            cz_reg[0] <= z0;
            zr_reg[0] <= fl_reg[NORM_STEPS].zero;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [CW-1:0] dx, dy;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (cy_reg[i] >= 0) begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_TAB[i];
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_TAB[i];
                end
                zr_reg[i+1] <= zr_reg[i];
            end
        end
    end

    always_comb begin
        zsum = cz_reg[CORDIC_STEPS] + ROUND_OFS;
        zq   = zsum >>> 16;
        if (zr_reg[CORDIC_STEPS]) begin
            angle_next = '0;
        end else if (zq > CW'(ANG_LIM)) begin
            angle_next = ANG_LIM;
        end else if (zq < -CW'(ANG_LIM)) begin
            angle_next = -ANG_LIM;
        end else begin
            angle_next = 16'(zq);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule
